@@ hw/rtl/pvcc_pkg.sv @@
// Shared types and constants of the pulse value consistency cache.
// Used by pvcc_cell and pulse_value_consistency_cache_top; depends on nothing.
package pvcc_pkg;

  localparam int unsigned ENTRIES         = 10;
  localparam int unsigned WORDS_PER_ENTRY = 16;
  localparam int unsigned MAX_WORDS       = 16;
  localparam int unsigned KEY_W           = 32;
  localparam int unsigned WORD_W          = 32;
  localparam int unsigned IDX_W           = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef logic [KEY_W-1:0]                    key_t;
  typedef logic [IDX_W-1:0]                    idx_t;
  typedef logic [WORDS_PER_ENTRY-1:0][WORD_W-1:0] words_t;

  typedef enum logic [1:0] {
    OUT_STORED   = 2'd0,
    OUT_MATCH    = 2'd1,
    OUT_MISMATCH = 2'd2
  } outcome_e;

  // Running scan record handed from cell to cell.
  typedef struct packed {
    logic vld;
    logic hit;
    logic same;
    logic free_fnd;
    idx_t free_idx;
    logic min_fnd;
    key_t min_key;
    idx_t min_idx;
  } scan_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

endpackage

@@ hw/rtl/pvcc_cell.sv @@
// One table entry: valid bit, key and words, plus one stage of the scan chain.
// Depends on pvcc_pkg.
module pvcc_cell import pvcc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  idx_t   idx_i,
  input  key_t   key_i,
  input  words_t words_i,
  input  logic   wr_i,
  input  scan_t  scan_i,
  output scan_t  scan_o
);

  logic   valid_q;
  key_t   key_q;
  words_t words_q;
  scan_t  scan_d, scan_q;
  logic   same;

  assign same = (words_q == words_i);

  always_comb begin
    scan_d = scan_i;
    if (valid_q) begin
      if (key_q == key_i) begin
        scan_d.hit  = 1'b1;
        scan_d.same = same;
      end
      if (!scan_i.min_fnd || (key_q < scan_i.min_key)) begin
        scan_d.min_fnd = 1'b1;
        scan_d.min_key = key_q;
        scan_d.min_idx = idx_i;
      end
    end else if (!scan_i.free_fnd) begin
      scan_d.free_fnd = 1'b1;
      scan_d.free_idx = idx_i;
    end
    if (!scan_i.vld) begin
      scan_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      scan_q  <= '0;
    end else begin
      scan_q <= scan_d;
      if (wr_i) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      key_q   <= key_i;
      words_q <= words_i;
    end
  end

  assign scan_o = scan_q;

endmodule

@@ hw/rtl/pulse_value_consistency_cache_top.sv @@
// Top level of the pulse value consistency cache: handshakes, control and the cell row.
// Depends on pvcc_pkg and pvcc_cell.

// Each word carries a key and sixteen data words. A scan record walks the row of
// ENTRIES cells, one cell per cycle, collecting hit, first free slot and smallest
// key. Once accepted, a word passes the start register, the cell row and the result
// register; its outcome then enters the output register in the same cycle as the
// input reopens, so words are taken one at a time. A finished outcome waits in
// the output register while the next word is accepted; a stalled outcome holds
// the following one back, and with it the input. Outcome: 0 stored, 1 match,
// 2 mismatch. On a miss with a full table the entry with the smallest key is
// replaced.
module pulse_value_consistency_cache_top import pvcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] pulse_key_i,
  input  logic [63:0] words_0_1_i,
  input  logic [63:0] words_2_3_i,
  input  logic [63:0] words_4_5_i,
  input  logic [63:0] words_6_7_i,
  input  logic [63:0] words_8_9_i,
  input  logic [63:0] words_10_11_i,
  input  logic [63:0] words_12_13_i,
  input  logic [63:0] words_14_15_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  outcome_o
);

  logic [MAX_WORDS-1:0][WORD_W-1:0] all_words;
  key_t     key_q;
  words_t   words_q;
  state_e   state_d, state_q;
  logic     start_q;
  logic     accept;
  logic     done;
  scan_t    seed;
  scan_t    chain [ENTRIES+1];
  idx_t     slot;
  logic [ENTRIES-1:0] wr;
  outcome_e res_d, res_q;
  logic     out_valid_d, out_valid_q;
  outcome_e out_d, out_q;

  assign all_words = {words_14_15_i, words_12_13_i, words_10_11_i, words_8_9_i,
                      words_6_7_i, words_4_5_i, words_2_3_i, words_0_1_i};

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q   <= pulse_key_i;
      words_q <= all_words[WORDS_PER_ENTRY-1:0];
    end
  end

  always_comb begin
    seed     = '0;
    seed.vld = start_q;
  end

  assign chain[0] = seed;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign wr[i] = done && !chain[ENTRIES].hit && (slot == idx_t'(i));

    pvcc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (idx_t'(i)),
      .key_i   (key_q),
      .words_i (words_q),
      .wr_i    (wr[i]),
      .scan_i  (chain[i]),
      .scan_o  (chain[i+1])
    );
  end

  assign done = chain[ENTRIES].vld;
  assign slot = chain[ENTRIES].free_fnd ? chain[ENTRIES].free_idx : chain[ENTRIES].min_idx;

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (done) begin
          if (!chain[ENTRIES].hit) begin
            res_d = OUT_STORED;
          end else if (chain[ENTRIES].same) begin
            res_d = OUT_MATCH;
          end else begin
            res_d = OUT_MISMATCH;
          end
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= accept;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign outcome_o   = out_q;

endmodule

@@ verif/pulse_value_consistency_cache_top_test.sv @@
// Testbench for pulse_value_consistency_cache_top: drives keyed 16-word pulses in bursts,
// tracks the key table in a local predictor and checks every outcome in order.
// Depends on pvcc_pkg and the cache RTL.
module pulse_value_consistency_cache_top_test import pvcc_pkg::*; ();

  localparam int unsigned DATA_W      = MAX_WORDS * WORD_W;
  localparam int unsigned POOL_KEYS   = 14;
  localparam int unsigned RAND_PULSES = 1350;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    key_t              key;
    logic [DATA_W-1:0] data;
  } pulse_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic              in_valid  = 1'b0;
  logic              in_ready;
  key_t              drv_key   = '0;
  logic [DATA_W-1:0] drv_data  = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        outcome;

  pulse_t   pulse_queue[$];
  outcome_e outcome_queue[$];

  logic              tbl_used [ENTRIES];
  key_t              tbl_key  [ENTRIES];
  logic [DATA_W-1:0] tbl_data [ENTRIES];

  int unsigned n_stored   = 0;
  int unsigned n_evicted  = 0;
  int unsigned n_matched  = 0;
  int unsigned n_differ   = 0;
  int unsigned n_checked  = 0;
  int unsigned errors     = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned cyc        = 0;
  int unsigned idle_cnt   = 0;

  always #2 clk_i = ~clk_i;

  pulse_value_consistency_cache_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .pulse_key_i   (drv_key),
    .words_0_1_i   (drv_data[63:0]),
    .words_2_3_i   (drv_data[127:64]),
    .words_4_5_i   (drv_data[191:128]),
    .words_6_7_i   (drv_data[255:192]),
    .words_8_9_i   (drv_data[319:256]),
    .words_10_11_i (drv_data[383:320]),
    .words_12_13_i (drv_data[447:384]),
    .words_14_15_i (drv_data[511:448]),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .outcome_o     (outcome)
  );

  function automatic outcome_e classify_pulse(input key_t key, input logic [DATA_W-1:0] data);
    int   hit_at;
    int   free_at;
    int   min_at;
    int   slot;
    logic same;
    hit_at  = -1;
    free_at = -1;
    min_at  = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_used[i]) begin
        if (tbl_key[i] == key) hit_at = i;
        if (min_at < 0 || tbl_key[i] < tbl_key[min_at]) min_at = i;
      end else if (free_at < 0) begin
        free_at = i;
      end
    end
    if (hit_at >= 0) begin
      same = 1'b1;
      for (int w = 0; w < WORDS_PER_ENTRY; w++) begin
        if (tbl_data[hit_at][w*WORD_W +: WORD_W] != data[w*WORD_W +: WORD_W]) same = 1'b0;
      end
      if (same) begin
        n_matched++;
        return OUT_MATCH;
      end
      n_differ++;
      return OUT_MISMATCH;
    end
    slot = (free_at >= 0) ? free_at : min_at;
    if (free_at < 0) n_evicted++;
    tbl_used[slot] = 1'b1;
    tbl_key[slot]  = key;
    tbl_data[slot] = data;
    n_stored++;
    return OUT_STORED;
  endfunction

  function automatic logic [DATA_W-1:0] random_words();
    logic [DATA_W-1:0] d;
    int unsigned       pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    for (int w = 0; w < MAX_WORDS; w++) d[w*WORD_W +: WORD_W] = $urandom;
    return d;
  endfunction

  function automatic logic [DATA_W-1:0] flip_one_bit(input logic [DATA_W-1:0] d);
    return d ^ ({{(DATA_W-1){1'b0}}, 1'b1} << $urandom_range(0, DATA_W - 1));
  endfunction

  task automatic push_pulse(input key_t key, input logic [DATA_W-1:0] data);
    pulse_t p;
    p.key  = key;
    p.data = data;
    pulse_queue.push_back(p);
  endtask

  // Driver: accept, predict, then load the next word or hold a gap.
  always @(posedge clk_i or negedge rst_ni) begin
    pulse_t p;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        outcome_queue.push_back(classify_pulse(drv_key, drv_data));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pulse_queue.size() > 0) begin
          p = pulse_queue.pop_front();
          in_valid <= 1'b1;
          drv_key  <= p.key;
          drv_data <= p.data;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall on its own pattern, check each outcome against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_e want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      cyc++;
      if (cyc[8]) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 25);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      if (out_valid && out_ready) begin
        n_checked++;
        if (outcome_queue.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected outcome %0d with nothing pending", outcome);
        end else begin
          want = outcome_queue.pop_front();
          if (outcome !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("outcome mismatch on word %0d: expected %0d (%s), got %0d",
                       n_checked, want, want.name(), outcome);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cnt <= 0;
      end else if (idle_cnt >= IDLE_LIMIT) begin
        $display("no handshake for %0d cycles, %0d outcomes pending", idle_cnt,
                 outcome_queue.size());
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  initial begin
    key_t              key_pool [POOL_KEYS];
    logic [DATA_W-1:0] last_data [key_t];
    key_t              key;
    logic [DATA_W-1:0] data;
    int unsigned       pick;

    for (int i = 0; i < ENTRIES; i++) begin
      tbl_used[i] = 1'b0;
      tbl_key[i]  = '0;
      tbl_data[i] = '0;
    end

    // Directed: extreme keys and words, match, mismatch, fill, eviction.
    push_pulse(32'h0, '0);
    push_pulse(32'h0, '0);
    push_pulse(32'h0, {{(DATA_W-1){1'b0}}, 1'b1} << (DATA_W - 1));
    push_pulse(32'hFFFF_FFFF, '1);
    push_pulse(32'hFFFF_FFFF, '1);
    push_pulse(32'hFFFF_FFFF, {{(DATA_W-1){1'b1}}, 1'b0});
    for (int k = 1; k <= 8; k++) push_pulse(k, {MAX_WORDS{32'(k)}});
    push_pulse(32'd100, '1);
    push_pulse(32'h0, '1);
    push_pulse(32'd100, '1);
    push_pulse(32'd2, '0);
    push_pulse(32'h0, '1);
    push_pulse(32'd1, '0);
    push_pulse(32'hFFFF_FFFF, '1);

    for (int i = 0; i < POOL_KEYS; i++) key_pool[i] = $urandom;
    for (int n = 0; n < RAND_PULSES; n++) begin
      if (n % 300 == 299) key_pool[$urandom_range(0, POOL_KEYS - 1)] = $urandom;
      key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, POOL_KEYS - 1)] : $urandom;
      if (last_data.exists(key)) begin
        pick = $urandom_range(0, 3);
        if (pick < 2) data = last_data[key];
        else if (pick == 2) data = flip_one_bit(last_data[key]);
        else data = random_words();
      end else begin
        data = random_words();
        last_data[key] = data;
      end
      push_pulse(key, data);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pulse_queue.size() > 0 || in_valid || outcome_queue.size() > 0) @(posedge clk_i);
    repeat (2 * (ENTRIES + 3) + 8) @(posedge clk_i);

    $display("%0d outcomes checked: %0d stored (%0d by eviction), %0d matched, %0d differed",
             n_checked, n_stored, n_evicted, n_matched, n_differ);
    $display("%0d mismatches in total", errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
